// ===== hdl/ddp_pkg.sv =====
// ----------------------------------------------------------------------------
// ddp_pkg
// Shared types, widths and register codes for the differential drive
// speed profile and PD position loop.
// ----------------------------------------------------------------------------
package ddp_pkg;

   localparam int CountW  = 32;   // encoder counts, totals, errors, drives
   localparam int SpeedW  = 16;   // ramped and target speeds
   localparam int StepW   = 12;   // ramp step registers
   localparam int GainW   = 8;    // PD gains
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 12;   // widest register
   localparam int PwmW    = 43;   // one PD law output, gain * error terms
   localparam int MixW    = PwmW + 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FWD_ACCEL   = 3'd0,
      CSR_FWD_DECEL   = 3'd1,
      CSR_TURN_ACCEL  = 3'd2,
      CSR_TURN_DECEL  = 3'd3,
      CSR_FWD_PGAIN   = 3'd4,
      CSR_FWD_DGAIN   = 3'd5,
      CSR_TURN_PGAIN  = 3'd6,
      CSR_TURN_DGAIN  = 3'd7
   } csr_reg_type;

   typedef enum logic {
      KIND_TICK    = 1'b0,
      KIND_RESTART = 1'b1
   } kind_type;

   typedef struct packed {
      logic [StepW-1:0] fwd_accel_step;
      logic [StepW-1:0] fwd_decel_step;
      logic [StepW-1:0] turn_accel_step;
      logic [StepW-1:0] turn_decel_step;
      logic [GainW-1:0] fwd_prop_gain;
      logic [GainW-1:0] fwd_deriv_gain;
      logic [GainW-1:0] turn_prop_gain;
      logic [GainW-1:0] turn_deriv_gain;
   } cfg_type;

   typedef struct packed {
      logic                     kind;
      logic signed [CountW-1:0] left_count;
      logic signed [CountW-1:0] right_count;
      logic signed [SpeedW-1:0] target_fwd_speed;
      logic signed [SpeedW-1:0] target_turn_speed;
   } req_item_type;

   // state snapshot after one item, handed to the PD stages
   typedef struct packed {
      logic                     kind;
      logic signed [CountW-1:0] fwd_error;
      logic signed [CountW-1:0] turn_error;
      logic signed [CountW-1:0] last_fwd_error;
      logic signed [CountW-1:0] last_turn_error;
      logic signed [CountW-1:0] travelled;
      logic signed [CountW-1:0] left_total;
      logic signed [CountW-1:0] right_total;
      logic signed [SpeedW-1:0] fwd_speed;
      logic signed [SpeedW-1:0] turn_speed;
   } track_type;

   typedef struct packed {
      logic signed [CountW-1:0] left_drive;
      logic signed [CountW-1:0] right_drive;
      logic signed [CountW-1:0] travelled;
      logic signed [CountW-1:0] mean_total;
      logic signed [SpeedW-1:0] fwd_speed_now;
      logic signed [SpeedW-1:0] turn_speed_now;
   } rsp_item_type;

   // pipeline advance strobes for the track, product and result registers
   typedef struct packed {
      logic adv_track;
      logic adv_prod;
      logic adv_out;
   } stage_ctl_type;

endpackage

// ===== hdl/ddp_req_if.sv =====
// ----------------------------------------------------------------------------
// ddp_req_if
// Input channel: valid/ready handshake with one control-tick transaction.
// ----------------------------------------------------------------------------
interface ddp_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      kind;
   logic signed [ddp_pkg::CountW-1:0]         left_count;
   logic signed [ddp_pkg::CountW-1:0]         right_count;
   logic signed [ddp_pkg::SpeedW-1:0]         target_fwd_speed;
   logic signed [ddp_pkg::SpeedW-1:0]         target_turn_speed;

   modport source (output valid, kind, left_count, right_count,
                   target_fwd_speed, target_turn_speed, input ready);
   modport sink   (input valid, kind, left_count, right_count,
                   target_fwd_speed, target_turn_speed, output ready);
endinterface

// ===== hdl/ddp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ddp_rsp_if
// Result channel: valid/ready handshake with one drive transaction.
// ----------------------------------------------------------------------------
interface ddp_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [ddp_pkg::CountW-1:0]         left_drive;
   logic signed [ddp_pkg::CountW-1:0]         right_drive;
   logic signed [ddp_pkg::CountW-1:0]         travelled;
   logic signed [ddp_pkg::CountW-1:0]         mean_total;
   logic signed [ddp_pkg::SpeedW-1:0]         fwd_speed_now;
   logic signed [ddp_pkg::SpeedW-1:0]         turn_speed_now;

   modport source (output valid, left_drive, right_drive, travelled, mean_total,
                   fwd_speed_now, turn_speed_now, input ready);
   modport sink   (input valid, left_drive, right_drive, travelled, mean_total,
                   fwd_speed_now, turn_speed_now, output ready);
endinterface

// ===== hdl/ddp_track.sv =====
// ----------------------------------------------------------------------------
// ddp_track
// Odometry, speed ramps and position error update. Holds the loop state;
// one transaction per cycle while ctl.adv_track is set, result registered for the PD stages.
// ----------------------------------------------------------------------------
module ddp_track (
   input  logic                    clock,
   input  logic                    reset,
   input  ddp_pkg::stage_ctl_type  ctl,
   input  ddp_pkg::cfg_type        cfg,
   input  ddp_pkg::req_item_type   item,
   output ddp_pkg::track_type      trk
);

   localparam int W  = ddp_pkg::CountW;
   localparam int SW = ddp_pkg::SpeedW;
   localparam int EW = W + 3;   // error + speed - feedback

   function automatic logic signed [SW-1:0] ramp(
      input logic signed [SW-1:0]             cur,
      input logic signed [SW-1:0]             target,
      input logic [ddp_pkg::StepW-1:0]        up,
      input logic [ddp_pkg::StepW-1:0]        down
   );
      logic signed [SW+1:0] s;
      logic signed [SW-1:0] r;
      r = cur;
      s = (SW+2)'(cur);
      // at the target the speed holds
      if (cur < target) begin
         s = (SW+2)'(cur) + (SW+2)'(signed'({1'b0, up}));
         r = (s > (SW+2)'(target)) ? target : s[SW-1:0];
      end else if (cur > target) begin
         s = (SW+2)'(cur) - (SW+2)'(signed'({1'b0, down}));
         r = (s < (SW+2)'(target)) ? target : s[SW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [W-1:0] sat_err(input logic signed [EW-1:0] x);
      logic signed [W-1:0] r;
      if (x[EW-1:W-1] == {(EW-W+1){x[EW-1]}}) begin
         r = x[W-1:0];
      end else begin
         r = {x[EW-1], {(W-1){~x[EW-1]}}};
      end
      return r;
   endfunction

   logic signed [W-1:0]  prev_left_ff, prev_left_in;
   logic signed [W-1:0]  prev_right_ff, prev_right_in;
   logic signed [W-1:0]  left_total_ff, left_total_in;
   logic signed [W-1:0]  right_total_ff, right_total_in;
   logic signed [W-1:0]  distance_ff, distance_in;
   logic signed [SW-1:0] fwd_speed_ff, fwd_speed_in;
   logic signed [SW-1:0] turn_speed_ff, turn_speed_in;
   logic signed [W-1:0]  fwd_error_ff, fwd_error_in;
   logic signed [W-1:0]  turn_error_ff, turn_error_in;
   logic signed [W-1:0]  last_fwd_error_ff, last_fwd_error_in;
   logic signed [W-1:0]  last_turn_error_ff, last_turn_error_in;
   ddp_pkg::track_type   trk_ff, trk_in;

   logic signed [W-1:0]  dl, dr;
   logic signed [W:0]    fb_x, fb_w, half_adj;
   logic signed [W-1:0]  half_step;

   always_comb begin
      dl       = item.left_count - prev_left_ff;
      dr       = item.right_count - prev_right_ff;
      fb_x     = (W+1)'(dl) + (W+1)'(dr);
      fb_w     = (W+1)'(dl) - (W+1)'(dr);
      // halve toward zero
      half_adj  = fb_x + (W+1)'(fb_x[W]);
      half_step = half_adj[W:1];

      prev_left_in       = prev_left_ff;
      prev_right_in      = prev_right_ff;
      left_total_in      = left_total_ff;
      right_total_in     = right_total_ff;
      distance_in        = distance_ff;
      fwd_speed_in       = fwd_speed_ff;
      turn_speed_in      = turn_speed_ff;
      fwd_error_in       = fwd_error_ff;
      turn_error_in      = turn_error_ff;
      last_fwd_error_in  = last_fwd_error_ff;
      last_turn_error_in = last_turn_error_ff;

      unique case (ddp_pkg::kind_type'(item.kind))
         ddp_pkg::KIND_RESTART: begin
            prev_left_in   = '0;
            prev_right_in  = '0;
            left_total_in  = '0;
            right_total_in = '0;
            distance_in    = '0;
            fwd_speed_in   = '0;
            turn_speed_in  = '0;
         end
         ddp_pkg::KIND_TICK: begin
            prev_left_in   = item.left_count;
            prev_right_in  = item.right_count;
            left_total_in  = left_total_ff + dl;
            right_total_in = right_total_ff + dr;
            distance_in    = distance_ff + half_step;
            fwd_speed_in   = ramp(fwd_speed_ff, item.target_fwd_speed,
                                  cfg.fwd_accel_step, cfg.fwd_decel_step);
            turn_speed_in  = ramp(turn_speed_ff, item.target_turn_speed,
                                  cfg.turn_accel_step, cfg.turn_decel_step);
            fwd_error_in   = sat_err(EW'(fwd_error_ff) + EW'(fwd_speed_in) - EW'(fb_x));
            turn_error_in  = sat_err(EW'(turn_error_ff) + EW'(turn_speed_in) - EW'(fb_w));
            last_fwd_error_in  = fwd_error_in;
            last_turn_error_in = turn_error_in;
         end
         default: ;
      endcase

      trk_in.kind            = item.kind;
      trk_in.fwd_error       = fwd_error_in;
      trk_in.turn_error      = turn_error_in;
      trk_in.last_fwd_error  = last_fwd_error_ff;
      trk_in.last_turn_error = last_turn_error_ff;
      trk_in.travelled       = distance_in;
      trk_in.left_total      = left_total_in;
      trk_in.right_total     = right_total_in;
      trk_in.fwd_speed       = fwd_speed_in;
      trk_in.turn_speed      = turn_speed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff       <= '0;
         prev_right_ff      <= '0;
         left_total_ff      <= '0;
         right_total_ff     <= '0;
         distance_ff        <= '0;
         fwd_speed_ff       <= '0;
         turn_speed_ff      <= '0;
         fwd_error_ff       <= '0;
         turn_error_ff      <= '0;
         last_fwd_error_ff  <= '0;
         last_turn_error_ff <= '0;
      end else if (ctl.adv_track) begin
         prev_left_ff       <= prev_left_in;
         prev_right_ff      <= prev_right_in;
         left_total_ff      <= left_total_in;
         right_total_ff     <= right_total_in;
         distance_ff        <= distance_in;
         fwd_speed_ff       <= fwd_speed_in;
         turn_speed_ff      <= turn_speed_in;
         fwd_error_ff       <= fwd_error_in;
         turn_error_ff      <= turn_error_in;
         last_fwd_error_ff  <= last_fwd_error_in;
         last_turn_error_ff <= last_turn_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_track) begin
         trk_ff <= trk_in;
      end
   end

   assign trk = trk_ff;

endmodule

// ===== hdl/ddp_pd.sv =====
// ----------------------------------------------------------------------------
// ddp_pd
// PD laws and drive mixing: a product stage (gain times error terms) and a
// mix stage that saturates into the result register.
// ----------------------------------------------------------------------------
module ddp_pd (
   input  logic                    clock,
   input  ddp_pkg::stage_ctl_type  ctl,
   input  ddp_pkg::cfg_type        cfg,
   input  ddp_pkg::track_type      trk,
   output ddp_pkg::rsp_item_type   rsp_item
);

   localparam int W  = ddp_pkg::CountW;
   localparam int SW = ddp_pkg::SpeedW;
   localparam int PW = ddp_pkg::PwmW;
   localparam int MW = ddp_pkg::MixW;
   localparam int GW = ddp_pkg::GainW + 1;   // gain as a positive signed value
   localparam int QW = GW + W + 1;           // gain * error difference

   function automatic logic signed [W-1:0] sat_drive(input logic signed [MW-1:0] x);
      logic signed [W-1:0] r;
      if (x[MW-1:W-1] == {(MW-W+1){x[MW-1]}}) begin
         r = x[W-1:0];
      end else begin
         r = {x[MW-1], {(W-1){~x[MW-1]}}};
      end
      return r;
   endfunction

   // product stage
   logic signed [GW-1:0] fpg, fdg, tpg, tdg;
   logic signed [W:0]    fwd_diff, turn_diff;
   logic signed [QW-1:0] fwd_p, fwd_d, turn_p, turn_d;
   logic signed [PW-1:0] pwm_x_in, pwm_w_in, pwm_x_ff, pwm_w_ff;
   logic signed [W:0]    mean_sum, mean_adj;
   logic                 kind_ff;
   logic signed [W-1:0]  travelled_ff, mean_ff;
   logic signed [SW-1:0] fwd_speed_ff, turn_speed_ff;

   // mix stage
   logic signed [MW-1:0]   left_sum, right_sum;
   ddp_pkg::rsp_item_type  rsp_ff, rsp_in;

   always_comb begin
      fpg       = signed'({1'b0, cfg.fwd_prop_gain});
      fdg       = signed'({1'b0, cfg.fwd_deriv_gain});
      tpg       = signed'({1'b0, cfg.turn_prop_gain});
      tdg       = signed'({1'b0, cfg.turn_deriv_gain});
      fwd_diff  = (W+1)'(trk.fwd_error) - (W+1)'(trk.last_fwd_error);
      turn_diff = (W+1)'(trk.turn_error) - (W+1)'(trk.last_turn_error);
      fwd_p     = fpg * trk.fwd_error;
      fwd_d     = fdg * fwd_diff;
      turn_p    = tpg * trk.turn_error;
      turn_d    = tdg * turn_diff;
      pwm_x_in  = PW'(fwd_p) + PW'(fwd_d);
      pwm_w_in  = PW'(turn_p) + PW'(turn_d);
      // wheel total mean, toward zero
      mean_sum  = (W+1)'(trk.left_total) + (W+1)'(trk.right_total);
      mean_adj  = mean_sum + (W+1)'(mean_sum[W]);
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_prod) begin
         kind_ff       <= trk.kind;
         pwm_x_ff      <= pwm_x_in;
         pwm_w_ff      <= pwm_w_in;
         travelled_ff  <= trk.travelled;
         mean_ff       <= mean_adj[W:1];
         fwd_speed_ff  <= trk.fwd_speed;
         turn_speed_ff <= trk.turn_speed;
      end
   end

   always_comb begin
      left_sum  = MW'(pwm_x_ff) + MW'(pwm_w_ff);
      right_sum = MW'(pwm_x_ff) - MW'(pwm_w_ff);
      rsp_in.travelled      = travelled_ff;
      rsp_in.mean_total     = mean_ff;
      rsp_in.fwd_speed_now  = fwd_speed_ff;
      rsp_in.turn_speed_now = turn_speed_ff;
      unique case (ddp_pkg::kind_type'(kind_ff))
         ddp_pkg::KIND_RESTART: begin
            rsp_in.left_drive  = '0;
            rsp_in.right_drive = '0;
         end
         ddp_pkg::KIND_TICK: begin
            rsp_in.left_drive  = sat_drive(left_sum);
            rsp_in.right_drive = sat_drive(right_sum);
         end
         default: begin
            rsp_in.left_drive  = '0;
            rsp_in.right_drive = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ===== hdl/differential_drive_profile_pd_top.sv =====
// ----------------------------------------------------------------------------
// differential_drive_profile_pd_top
// Differential drive speed ramp with PD position loop, four-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one control-tick transaction: a kind bit (tick or
//    restart), the raw left/right encoder counts and the target forward and
//    turn speeds. rsp_chan returns exactly one transaction per request with
//    the saturated left/right drives, distance, mean wheel total and the
//    ramped speeds, in request order.
//  - The input register loads at acceptance; the transaction then passes
//    the state update (odometry, ramps, errors), PD product and drive mix
//    registers in that order before rsp_chan.valid rises.
//  - Throughput is one transaction per cycle while rsp_chan.ready is high;
//    the loop state lives in the state update stage, which closes its recurrence through its own registers.
//  - csr_we/csr_index/csr_wdata write the ramp steps and PD gains; write
//    them only while the pipeline is empty.
//  - Reset (synchronous) clears the loop state, the configuration registers
//    and all stage valids; no clearing pass is needed.
//  - A stalled receiver holds the result register; earlier stages keep
//    filling bubbles, and req_chan.ready drops only once every stage holds
//    a transaction.
// ----------------------------------------------------------------------------
module differential_drive_profile_pd_top (
   input  logic                               clock,
   input  logic                               reset,
   ddp_req_if.sink                            req_chan,
   ddp_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [ddp_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [ddp_pkg::CsrDatW-1:0]        csr_wdata
);

   // configuration registers
   ddp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (ddp_pkg::csr_reg_type'(csr_index))
            ddp_pkg::CSR_FWD_ACCEL:  cfg_ff.fwd_accel_step  <= csr_wdata[ddp_pkg::StepW-1:0];
            ddp_pkg::CSR_FWD_DECEL:  cfg_ff.fwd_decel_step  <= csr_wdata[ddp_pkg::StepW-1:0];
            ddp_pkg::CSR_TURN_ACCEL: cfg_ff.turn_accel_step <= csr_wdata[ddp_pkg::StepW-1:0];
            ddp_pkg::CSR_TURN_DECEL: cfg_ff.turn_decel_step <= csr_wdata[ddp_pkg::StepW-1:0];
            ddp_pkg::CSR_FWD_PGAIN:  cfg_ff.fwd_prop_gain   <= csr_wdata[ddp_pkg::GainW-1:0];
            ddp_pkg::CSR_FWD_DGAIN:  cfg_ff.fwd_deriv_gain  <= csr_wdata[ddp_pkg::GainW-1:0];
            ddp_pkg::CSR_TURN_PGAIN: cfg_ff.turn_prop_gain  <= csr_wdata[ddp_pkg::GainW-1:0];
            ddp_pkg::CSR_TURN_DGAIN: cfg_ff.turn_deriv_gain <= csr_wdata[ddp_pkg::GainW-1:0];
            default: ;
         endcase
      end
   end

   // stage valids: input, track, product, result
   logic v_in_ff, v_in_in;
   logic v_trk_ff, v_trk_in;
   logic v_prod_ff, v_prod_in;
   logic v_out_ff, v_out_in;
   logic rdy_out, rdy_prod, rdy_trk, rdy_in, adv_in;
   ddp_pkg::stage_ctl_type ctl;

   // each stage may load when it is empty or the next one moves
   always_comb begin
      rdy_out       = !v_out_ff || rsp_chan.ready;
      rdy_prod      = !v_prod_ff || rdy_out;
      rdy_trk       = !v_trk_ff || rdy_prod;
      rdy_in        = !v_in_ff || rdy_trk;
      adv_in        = req_chan.valid && rdy_in;
      ctl.adv_out   = v_prod_ff && rdy_out;
      ctl.adv_prod  = v_trk_ff && rdy_prod;
      ctl.adv_track = v_in_ff && rdy_trk;
      v_in_in       = adv_in || (v_in_ff && !rdy_trk);
      v_trk_in      = ctl.adv_track || (v_trk_ff && !rdy_prod);
      v_prod_in     = ctl.adv_prod || (v_prod_ff && !rdy_out);
      v_out_in      = ctl.adv_out || (v_out_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff   <= 1'b0;
         v_trk_ff  <= 1'b0;
         v_prod_ff <= 1'b0;
         v_out_ff  <= 1'b0;
      end else begin
         v_in_ff   <= v_in_in;
         v_trk_ff  <= v_trk_in;
         v_prod_ff <= v_prod_in;
         v_out_ff  <= v_out_in;
      end
   end

   // input register
   ddp_pkg::req_item_type item_ff;

   always_ff @(posedge clock) begin
      if (adv_in) begin
         item_ff.kind              <= req_chan.kind;
         item_ff.left_count        <= req_chan.left_count;
         item_ff.right_count       <= req_chan.right_count;
         item_ff.target_fwd_speed  <= req_chan.target_fwd_speed;
         item_ff.target_turn_speed <= req_chan.target_turn_speed;
      end
   end

   ddp_pkg::track_type    trk;
   ddp_pkg::rsp_item_type rsp_item;

   ddp_track u_track (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .cfg   (cfg_ff),
      .item  (item_ff),
      .trk   (trk)
   );

   ddp_pd u_pd (
      .clock    (clock),
      .ctl      (ctl),
      .cfg      (cfg_ff),
      .trk      (trk),
      .rsp_item (rsp_item)
   );

   assign req_chan.ready          = rdy_in;
   assign rsp_chan.valid          = v_out_ff;
   assign rsp_chan.left_drive     = rsp_item.left_drive;
   assign rsp_chan.right_drive    = rsp_item.right_drive;
   assign rsp_chan.travelled      = rsp_item.travelled;
   assign rsp_chan.mean_total     = rsp_item.mean_total;
   assign rsp_chan.fwd_speed_now  = rsp_item.fwd_speed_now;
   assign rsp_chan.turn_speed_now = rsp_item.turn_speed_now;

endmodule
